// ----- rtl/cpu_alu_shift_bit_daa_unit_defines.svh -----
// Assertion macros for the ALU shift/bit/DAA unit checker.
`ifndef CPU_ALU_SHIFT_BIT_DAA_UNIT_DEFINES_SVH
`define CPU_ALU_SHIFT_BIT_DAA_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define CASBD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define CASBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/alu_sbd_pkg.sv -----
package alu_sbd_pkg;

  typedef enum logic [4:0] {
    OP_RLCA = 5'd0,
    OP_RRCA = 5'd1,
    OP_RLA  = 5'd2,
    OP_RRA  = 5'd3,
    OP_RLC  = 5'd4,
    OP_RRC  = 5'd5,
    OP_RL   = 5'd6,
    OP_RR   = 5'd7,
    OP_SLA  = 5'd8,
    OP_SRA  = 5'd9,
    OP_SWAP = 5'd10,
    OP_SRL  = 5'd11,
    OP_DAA  = 5'd12,
    OP_CPL  = 5'd13,
    OP_SCF  = 5'd14,
    OP_CCF  = 5'd15,
    OP_AND  = 5'd16,
    OP_XOR  = 5'd17,
    OP_OR   = 5'd18,
    OP_BIT  = 5'd19,
    OP_RES  = 5'd20,
    OP_SET  = 5'd21
  } op_t;

  localparam logic [7:0] DAA_LO_ADJ     = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ     = 8'h60;
  localparam logic [3:0] DAA_NIBBLE_MAX = 4'h9;
  localparam logic [7:0] DAA_BYTE_MAX   = 8'h99;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // decode stage output
  typedef struct packed {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] mask;
    logic [7:0] daa_adj;
    logic       daa_carry;
    flags_t     flags;
  } dec_t;

  // execute stage output
  typedef struct packed {
    logic [7:0] result;
    logic       z_from_result;
    flags_t     flags;
  } exe_t;

endpackage

// ----- rtl/alu_sbd_decode.sv -----
module alu_sbd_decode
  import alu_sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [4:0] op,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [2:0] bit_index,
  input  logic       zero_in,
  input  logic       subtract_in,
  input  logic       half_in,
  input  logic       carry_in,
  output logic       valid,
  input  logic       down_ready,
  output dec_t       dec
);

  dec_t dec_next;
  logic lo_fix;
  logic hi_fix;

  assign up_ready = !valid || down_ready;

  always_comb begin
    if (subtract_in) begin
      lo_fix = half_in;
      hi_fix = carry_in;
    end else begin
      lo_fix = half_in || (operand_a[3:0] > DAA_NIBBLE_MAX);
      hi_fix = carry_in || (operand_a > DAA_BYTE_MAX);
    end
    dec_next.op        = op_t'(op);
    dec_next.a         = operand_a;
    dec_next.b         = operand_b;
    dec_next.mask      = 8'(1) << bit_index;
    dec_next.daa_adj   = (lo_fix ? DAA_LO_ADJ : 8'h00) | (hi_fix ? DAA_HI_ADJ : 8'h00);
    dec_next.daa_carry = hi_fix;
    dec_next.flags     = '{z: zero_in, n: subtract_in, h: half_in, c: carry_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dec <= dec_next;
    end
  end

endmodule

// ----- rtl/alu_sbd_exec.sv -----
module alu_sbd_exec
  import alu_sbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  dec_t dec,
  output logic valid,
  input  logic down_ready,
  output exe_t exe
);

  exe_t       exe_next;
  logic [7:0] a;
  flags_t     fi;

  assign up_ready = !valid || down_ready;
  assign a        = dec.a;
  assign fi       = dec.flags;

  always_comb begin
    exe_next.result        = a;
    exe_next.z_from_result = 1'b0;
    exe_next.flags         = fi;
    case (dec.op)
      OP_RLCA: begin
        exe_next.result = {a[6:0], a[7]};
        exe_next.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RRCA: begin
        exe_next.result = {a[0], a[7:1]};
        exe_next.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_RLA: begin
        exe_next.result = {a[6:0], fi.c};
        exe_next.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RRA: begin
        exe_next.result = {fi.c, a[7:1]};
        exe_next.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_RLC: begin
        exe_next.result        = {a[6:0], a[7]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RRC: begin
        exe_next.result        = {a[0], a[7:1]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_RL: begin
        exe_next.result        = {a[6:0], fi.c};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_RR: begin
        exe_next.result        = {fi.c, a[7:1]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_SLA: begin
        exe_next.result        = {a[6:0], 1'b0};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      OP_SRA: begin
        exe_next.result        = {a[7], a[7:1]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_SWAP: begin
        exe_next.result        = {a[3:0], a[7:4]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_SRL: begin
        exe_next.result        = {1'b0, a[7:1]};
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      OP_DAA: begin
        exe_next.result        = fi.n ? (a - dec.daa_adj) : (a + dec.daa_adj);
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: fi.n, h: 1'b0,
                                   c: fi.n ? fi.c : dec.daa_carry};
      end
      OP_CPL: begin
        exe_next.result = ~a;
        exe_next.flags  = '{z: fi.z, n: 1'b1, h: 1'b1, c: fi.c};
      end
      OP_SCF: begin
        exe_next.flags = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        exe_next.flags = '{z: fi.z, n: 1'b0, h: 1'b0, c: !fi.c};
      end
      OP_AND: begin
        exe_next.result        = a & dec.b;
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        exe_next.result        = a ^ dec.b;
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        exe_next.result        = a | dec.b;
        exe_next.z_from_result = 1'b1;
        exe_next.flags         = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_BIT: begin
        exe_next.flags = '{z: ((a & dec.mask) == 8'h00), n: 1'b0, h: 1'b1, c: fi.c};
      end
      OP_RES: begin
        exe_next.result = a & ~dec.mask;
      end
      OP_SET: begin
        exe_next.result = a | dec.mask;
      end
      default: begin
        exe_next.result = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      exe <= exe_next;
    end
  end

endmodule

// ----- rtl/alu_sbd_flags.sv -----
module alu_sbd_flags
  import alu_sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  exe_t       exe,
  output logic       valid,
  input  logic       down_ready,
  output logic [7:0] result,
  output flags_t     flags
);

  flags_t flags_next;

  assign up_ready = !valid || down_ready;

  always_comb begin
    flags_next = exe.flags;
    if (exe.z_from_result) begin
      flags_next.z = (exe.result == 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      result <= exe.result;
      flags  <= flags_next;
    end
  end

endmodule

// ----- rtl/cpu_alu_shift_bit_daa_unit.sv -----
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  op, operand_a, operand_b, bit_index, *_in flags
// out      output     out_valid / out_stall result, zero_out, subtract_out, half_out, carry_out
//
// Three register stages (decode, execute, flags); one transfer per cycle while out_stall is low.
// Each stage holds its own valid bit and loads whenever it is empty or drains downstream.
// rst clears all valid bits at the next edge; a transfer is taken in the first cycle after.
// out_stall backs up stage by stage; in_stall rises only when all three stages are full.
module cpu_alu_shift_bit_daa_unit
  import alu_sbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] op,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic [2:0] bit_index,
  input  logic       zero_in,
  input  logic       subtract_in,
  input  logic       half_in,
  input  logic       carry_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result,
  output logic       zero_out,
  output logic       subtract_out,
  output logic       half_out,
  output logic       carry_out
);

  logic   dec_ready;
  logic   dec_valid;
  dec_t   dec;
  logic   exe_ready;
  logic   exe_valid;
  exe_t   exe;
  logic   flg_ready;
  flags_t flags;

  assign in_stall = !dec_ready;

  alu_sbd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_valid),
    .up_ready    (dec_ready),
    .op          (op),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .bit_index   (bit_index),
    .zero_in     (zero_in),
    .subtract_in (subtract_in),
    .half_in     (half_in),
    .carry_in    (carry_in),
    .valid       (dec_valid),
    .down_ready  (exe_ready),
    .dec         (dec)
  );

  alu_sbd_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (dec_valid),
    .up_ready   (exe_ready),
    .dec        (dec),
    .valid      (exe_valid),
    .down_ready (flg_ready),
    .exe        (exe)
  );

  alu_sbd_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (exe_valid),
    .up_ready   (flg_ready),
    .exe        (exe),
    .valid      (out_valid),
    .down_ready (!out_stall),
    .result     (result),
    .flags      (flags)
  );

  assign zero_out     = flags.z;
  assign subtract_out = flags.n;
  assign half_out     = flags.h;
  assign carry_out    = flags.c;

endmodule

// ----- rtl/alu_sbd_checker.sv -----
`include "cpu_alu_shift_bit_daa_unit_defines.svh"

module alu_sbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] result,
  input logic       zero_out,
  input logic       subtract_out,
  input logic       half_out,
  input logic       carry_out
);

  // in_stall can only rise when the output is held
  `CASBD_ASSERT(a_stall_needs_full, in_stall, out_valid && out_stall, "in_stall without backpressure")

  // with the output free, an accepted transfer passes the decode, execute and flags registers and shows up as out_valid
  `CASBD_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid, "transfer lost in pipe")

  // a held result keeps its value
  `CASBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result) && $stable({zero_out, subtract_out, half_out, carry_out}), "held result changed")

endmodule

bind cpu_alu_shift_bit_daa_unit alu_sbd_checker u_alu_sbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result       (result),
  .zero_out     (zero_out),
  .subtract_out (subtract_out),
  .half_out     (half_out),
  .carry_out    (carry_out)
);
